### rtl/msrb_pkg.sv
// ----------------------------------------------------------------------------
// msrb_pkg
// Shared types and constants for the multi-port serial ring buffers.
// ----------------------------------------------------------------------------
package msrb_pkg;

  localparam int PORTS_DEF    = 4;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 128;

  localparam int OP_W   = 3;
  localparam int PORT_W = 2;
  localparam int BYTE_W = 8;
  localparam int RXC_W  = 6;
  localparam int TXC_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_RX_STORE = 3'd0,
    OP_RX_READ  = 3'd1,
    OP_RX_PEEK  = 3'd2,
    OP_TX_WRITE = 3'd3,
    OP_TX_SEND  = 3'd4
  } op_e;

  // Where the result byte comes from once the memory read has returned.
  typedef enum logic [1:0] {
    BSRC_ZERO = 2'd0,
    BSRC_RX   = 2'd1,
    BSRC_TX   = 2'd2
  } bsrc_e;

  typedef struct packed {
    logic we;
    logic re;
  } ring_ctl_t;

  typedef struct packed {
    bsrc_e              src;
    logic               advanced;
    logic               tx_drained;
    logic [RXC_W-1:0]   rx_count;
    logic [TXC_W-1:0]   tx_count;
  } meta_t;

endpackage

### rtl/msrb_ring_mem.sv
// ----------------------------------------------------------------------------
// msrb_ring_mem
// Byte store for one ring per port, one write and one registered read port.
// ----------------------------------------------------------------------------
module msrb_ring_mem import msrb_pkg::*; #(
  parameter int PORTS = PORTS_DEF,
  parameter int DEPTH = RX_DEPTH_DEF
) (
  input  logic                                         clk_i,
  input  ring_ctl_t                                    ctl_i,
  input  logic [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0] port_i,
  input  logic [$clog2(DEPTH)-1:0]                     waddr_i,
  input  logic [BYTE_W-1:0]                            wdata_i,
  input  logic [$clog2(DEPTH)-1:0]                     raddr_i,
  output logic [BYTE_W-1:0]                            rdata_o
);

  logic [BYTE_W-1:0] mem_q [PORTS][DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[port_i][waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[port_i][raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/msrb_ctrl.sv
// ----------------------------------------------------------------------------
// msrb_ctrl
// Head and tail pointers per port, operation decode and fill counts.
// ----------------------------------------------------------------------------
module msrb_ctrl import msrb_pkg::*; #(
  parameter int PORTS    = PORTS_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         accept_i,
  input  logic [OP_W-1:0]                              op_i,
  input  logic [PORT_W-1:0]                            port_i,
  output logic [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0] port_idx_o,
  output ring_ctl_t                                    rx_ctl_o,
  output logic [$clog2(RX_DEPTH)-1:0]                  rx_waddr_o,
  output logic [$clog2(RX_DEPTH)-1:0]                  rx_raddr_o,
  output ring_ctl_t                                    tx_ctl_o,
  output logic [$clog2(TX_DEPTH)-1:0]                  tx_waddr_o,
  output logic [$clog2(TX_DEPTH)-1:0]                  tx_raddr_o,
  output meta_t                                        meta_o
);

  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
  localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
  localparam logic [RPW-1:0] RX_SPAN = RPW'(RX_DEPTH);
  localparam logic [TPW-1:0] TX_SPAN = TPW'(TX_DEPTH);

  logic [RPW-1:0] rx_head_q [PORTS];
  logic [RPW-1:0] rx_tail_q [PORTS];
  logic [TPW-1:0] tx_head_q [PORTS];
  logic [TPW-1:0] tx_tail_q [PORTS];
  // Set once the receive head has wrapped: every entry of the ring has then been written.
  logic           rx_wrap_q [PORTS];

  logic [PIW-1:0] pi;
  logic           port_ok;
  logic [RPW-1:0] rh, rt, rh_nx, rt_nx, rh_d, rt_d, rx_diff;
  logic [TPW-1:0] th, tt, th_nx, tt_nx, th_d, tt_d, tx_diff;
  logic           wrap, wrap_d;
  ring_ctl_t      rx_ctl, tx_ctl;
  bsrc_e          src;
  logic           adv;

  assign pi      = PIW'(port_i);
  assign port_ok = 32'(port_i) < 32'(PORTS);

  assign rh   = rx_head_q[pi];
  assign rt   = rx_tail_q[pi];
  assign th   = tx_head_q[pi];
  assign tt   = tx_tail_q[pi];
  assign wrap = rx_wrap_q[pi];

  assign rh_nx = (rh == RX_LAST) ? '0 : rh + RPW'(1);
  assign rt_nx = (rt == RX_LAST) ? '0 : rt + RPW'(1);
  assign th_nx = (th == TX_LAST) ? '0 : th + TPW'(1);
  assign tt_nx = (tt == TX_LAST) ? '0 : tt + TPW'(1);

  always_comb begin
    rx_ctl = '0;
    tx_ctl = '0;
    rh_d   = rh;
    rt_d   = rt;
    th_d   = th;
    tt_d   = tt;
    wrap_d = wrap;
    src    = BSRC_ZERO;
    adv    = 1'b0;
    rx_raddr_o = rt;
    tx_raddr_o = tt_nx;
    if (port_ok) begin
      case (op_e'(op_i))
        OP_RX_STORE: begin
          rx_ctl.we = 1'b1;
          rh_d      = rh_nx;
          if (rh == RX_LAST) begin
            wrap_d = 1'b1;
          end
        end
        OP_RX_READ: begin
          rx_ctl.re = 1'b1;
          src = (!wrap && rt >= rh) ? BSRC_ZERO : BSRC_RX;
          if (rh != rt) begin
            rt_d = rt_nx;
            adv  = 1'b1;
          end
        end
        OP_RX_PEEK: begin
          if (rh != rt) begin
            rx_ctl.re = 1'b1;
            src       = BSRC_RX;
          end
        end
        OP_TX_WRITE: begin
          tx_ctl.we = 1'b1;
          th_d      = th_nx;
        end
        OP_TX_SEND: begin
          if (th != tt) begin
            tx_ctl.re = 1'b1;
            tt_d      = tt_nx;
            src       = BSRC_TX;
            adv       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rx_diff = (rh_d >= rt_d) ? rh_d - rt_d : rh_d - rt_d + RX_SPAN;
  assign tx_diff = (th_d >= tt_d) ? th_d - tt_d : th_d - tt_d + TX_SPAN;

  always_comb begin
    meta_o = '0;
    if (port_ok) begin
      meta_o.src        = src;
      meta_o.advanced   = adv;
      meta_o.tx_drained = (th_d == tt_d);
      meta_o.rx_count   = RXC_W'(rx_diff);
      meta_o.tx_count   = TXC_W'(tx_diff);
    end
  end

  assign port_idx_o = pi;
  assign rx_waddr_o = rh;
  assign tx_waddr_o = th_nx;
  assign rx_ctl_o   = accept_i ? rx_ctl : '0;
  assign tx_ctl_o   = accept_i ? tx_ctl : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        rx_head_q[i] <= '0;
        rx_tail_q[i] <= '0;
        tx_head_q[i] <= '0;
        tx_tail_q[i] <= '0;
        rx_wrap_q[i] <= 1'b0;
      end
    end else if (accept_i && port_ok) begin
      rx_head_q[pi] <= rh_d;
      rx_tail_q[pi] <= rt_d;
      tx_head_q[pi] <= th_d;
      tx_tail_q[pi] <= tt_d;
      rx_wrap_q[pi] <= wrap_d;
    end
  end

endmodule

### rtl/multi_port_serial_ring_buffers.sv
// ----------------------------------------------------------------------------
// multi_port_serial_ring_buffers
// Receive and transmit byte rings for a set of serial ports.
//
//   Channel  Handshake                 Payload
//   input    in_valid_i / in_ready_o   op_i, port_i, data_i
//   output   out_valid_o / out_ready_i byte_out_o, advanced_o, tx_drained_o,
//                                      rx_count_o, tx_count_o
//
// One item is taken per cycle while the pipeline has room. The pointers are
// updated at the transfer and the byte memories are read then; the stage-one
// register holds it until its data is merged into the result register.
// Reset clears the pointers only; receive entries that were never written read
// as zero by tracking whether each head has wrapped, so no clearing pass runs.
// A stalled output holds the result and one further item in flight.
// ----------------------------------------------------------------------------
module multi_port_serial_ring_buffers import msrb_pkg::*; #(
  parameter int PORTS    = PORTS_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [PORT_W-1:0] port_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] byte_out_o,
  output logic              advanced_o,
  output logic              tx_drained_o,
  output logic [RXC_W-1:0]  rx_count_o,
  output logic [TXC_W-1:0]  tx_count_o
);

  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);

  logic              accept;
  logic [PIW-1:0]    port_idx;
  ring_ctl_t         rx_ctl, tx_ctl;
  logic [RPW-1:0]    rx_waddr, rx_raddr;
  logic [TPW-1:0]    tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata, byte_sel;
  meta_t             meta;

  logic              s1_valid_q;
  meta_t             s1_meta_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              adv_q, drained_q;
  logic [RXC_W-1:0]  rxc_q;
  logic [TXC_W-1:0]  txc_q;
  logic              out_free, s1_move;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  msrb_ctrl #(
    .PORTS    (PORTS),
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .port_i     (port_i),
    .port_idx_o (port_idx),
    .rx_ctl_o   (rx_ctl),
    .rx_waddr_o (rx_waddr),
    .rx_raddr_o (rx_raddr),
    .tx_ctl_o   (tx_ctl),
    .tx_waddr_o (tx_waddr),
    .tx_raddr_o (tx_raddr),
    .meta_o     (meta)
  );

  msrb_ring_mem #(
    .PORTS (PORTS),
    .DEPTH (RX_DEPTH)
  ) u_rx_mem (
    .clk_i   (clk_i),
    .ctl_i   (rx_ctl),
    .port_i  (port_idx),
    .waddr_i (rx_waddr),
    .wdata_i (data_i),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  msrb_ring_mem #(
    .PORTS (PORTS),
    .DEPTH (TX_DEPTH)
  ) u_tx_mem (
    .clk_i   (clk_i),
    .ctl_i   (tx_ctl),
    .port_i  (port_idx),
    .waddr_i (tx_waddr),
    .wdata_i (data_i),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    case (s1_meta_q.src)
      BSRC_RX: byte_sel = rx_rdata;
      BSRC_TX: byte_sel = tx_rdata;
      default: byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (s1_move) begin
      byte_q    <= byte_sel;
      adv_q     <= s1_meta_q.advanced;
      drained_q <= s1_meta_q.tx_drained;
      rxc_q     <= s1_meta_q.rx_count;
      txc_q     <= s1_meta_q.tx_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_out_o   = byte_q;
  assign advanced_o   = adv_q;
  assign tx_drained_o = drained_q;
  assign rx_count_o   = rxc_q;
  assign tx_count_o   = txc_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while the pipeline had room");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_meta_q))
    else $error("stalled item lost or changed");

  a_bad_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (32'(port_i) >= 32'(PORTS)) |=> s1_meta_q == '0)
    else $error("unused port produced a non-zero result");

  a_adv_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && meta.advanced |-> (rx_ctl.re || tx_ctl.re))
    else $error("byte consumed without a memory read");

endmodule

### bench/msrb_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrb_ring_checker
// Watches both channels of the serial ring buffers, keeps its own copy of the
// receive and transmit rings of every port, and compares each result transfer
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module msrb_ring_checker import msrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [PORT_W-1:0] port_i,
  input  logic [BYTE_W-1:0] data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] byte_out_i,
  input  logic              advanced_i,
  input  logic              tx_drained_i,
  input  logic [RXC_W-1:0]  rx_count_i,
  input  logic [TXC_W-1:0]  tx_count_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int PORTS    = PORTS_DEF;
  localparam int RX_DEPTH = RX_DEPTH_DEF;
  localparam int TX_DEPTH = TX_DEPTH_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              advanced;
    logic              drained;
    logic [RXC_W-1:0]  rx_cnt;
    logic [TXC_W-1:0]  tx_cnt;
  } ring_result_t;

  // The depths are powers of two that match the count widths, so the
  // pointers wrap on their own.
  logic [BYTE_W-1:0] rx_mem [PORTS][RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [PORTS][TX_DEPTH];
  logic [RXC_W-1:0]  rx_head [PORTS];
  logic [RXC_W-1:0]  rx_tail [PORTS];
  logic [TXC_W-1:0]  tx_head [PORTS];
  logic [TXC_W-1:0]  tx_tail [PORTS];

  ring_result_t outstanding_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic ring_result_t apply_ring_op(input logic [OP_W-1:0] op,
                                                 input logic [PORT_W-1:0] port,
                                                 input logic [BYTE_W-1:0] data);
    ring_result_t res;
    res = '0;
    if (32'(port) >= PORTS) begin
      return res;
    end
    case (op)
      OP_RX_STORE: begin
        rx_mem[port][rx_head[port]] = data;
        rx_head[port] = rx_head[port] + RXC_W'(1);
      end
      OP_RX_READ: begin
        res.byte_val = rx_mem[port][rx_tail[port]];
        if (rx_head[port] != rx_tail[port]) begin
          rx_tail[port] = rx_tail[port] + RXC_W'(1);
          res.advanced = 1'b1;
        end
      end
      OP_RX_PEEK: begin
        if (rx_head[port] != rx_tail[port]) begin
          res.byte_val = rx_mem[port][rx_tail[port]];
        end
      end
      OP_TX_WRITE: begin
        tx_head[port] = tx_head[port] + TXC_W'(1);
        tx_mem[port][tx_head[port]] = data;
      end
      OP_TX_SEND: begin
        if (tx_head[port] != tx_tail[port]) begin
          tx_tail[port] = tx_tail[port] + TXC_W'(1);
          res.byte_val = tx_mem[port][tx_tail[port]];
          res.advanced = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.drained = (tx_head[port] == tx_tail[port]);
    res.rx_cnt  = rx_head[port] - rx_tail[port];
    res.tx_cnt  = tx_head[port] - tx_tail[port];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t want;
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        rx_head[p] = '0;
        rx_tail[p] = '0;
        tx_head[p] = '0;
        tx_tail[p] = '0;
        for (int i = 0; i < RX_DEPTH; i++) rx_mem[p][i] = '0;
        for (int i = 0; i < TX_DEPTH; i++) tx_mem[p][i] = '0;
      end
      outstanding_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outstanding_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding",
                          32'(byte_out_i), 32'd0);
        end else begin
          want = outstanding_results.pop_front();
          if (byte_out_i !== want.byte_val)
            report_mismatch("byte_out", 32'(byte_out_i), 32'(want.byte_val));
          if (advanced_i !== want.advanced)
            report_mismatch("advanced", 32'(advanced_i), 32'(want.advanced));
          if (tx_drained_i !== want.drained)
            report_mismatch("tx_drained", 32'(tx_drained_i), 32'(want.drained));
          if (rx_count_i !== want.rx_cnt)
            report_mismatch("rx_count", 32'(rx_count_i), 32'(want.rx_cnt));
          if (tx_count_i !== want.tx_cnt)
            report_mismatch("tx_count", 32'(tx_count_i), 32'(want.tx_cnt));
        end
      end
      if (in_valid_i && in_ready_i) begin
        outstanding_results.push_back(apply_ring_op(op_i, port_i, data_i));
      end
      pending_o <= outstanding_results.size();
    end
  end

endmodule

### bench/tb_multi_port_serial_ring_buffers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_port_serial_ring_buffers
// Drives the serial ring buffers with a short directed sequence and then with
// random traffic that fills, drains and overruns the rings of each port, with
// bursty input and a stalling receiver. A separate checker judges every result.
// ----------------------------------------------------------------------------
module tb_multi_port_serial_ring_buffers;
  import msrb_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 300000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i        = '0;
  logic [PORT_W-1:0] port_i      = '0;
  logic [BYTE_W-1:0] data_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] byte_out_o;
  logic              advanced_o;
  logic              tx_drained_o;
  logic [RXC_W-1:0]  rx_count_o;
  logic [TXC_W-1:0]  tx_count_o;

  int fail_total;
  int pending_results;
  int accepted_ops     = 0;
  int burst_left       = 0;
  int cycle_count      = 0;
  int ready_mode       = 0;
  int ready_phase_left = 0;

  always #4 clk_i = ~clk_i;

  multi_port_serial_ring_buffers u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .port_i       (port_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_o   (byte_out_o),
    .advanced_o   (advanced_o),
    .tx_drained_o (tx_drained_o),
    .rx_count_o   (rx_count_o),
    .tx_count_o   (tx_count_o)
  );

  msrb_ring_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .port_i       (port_i),
    .data_i       (data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_i   (byte_out_o),
    .advanced_i   (advanced_o),
    .tx_drained_i (tx_drained_o),
    .rx_count_i   (rx_count_o),
    .tx_count_i   (tx_count_o),
    .fail_count_o (fail_total),
    .pending_o    (pending_results)
  );

  // The receiver switches between always ready, random, mostly stalled and
  // a regular on/off rhythm.
  always @(posedge clk_i) begin
    if (ready_phase_left == 0) begin
      ready_mode       <= $urandom_range(3);
      ready_phase_left <= $urandom_range(20, 150);
    end else begin
      ready_phase_left <= ready_phase_left - 1;
    end
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(1) == 1);
      2:       out_ready_i <= ($urandom_range(4) == 0);
      default: out_ready_i <= ready_phase_left[2];
    endcase
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                           input logic [BYTE_W-1:0] data);
    int gap;
    in_valid_i <= 1'b1;
    op_i       <= op;
    port_i     <= port;
    data_i     <= data;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    if (op <= OP_TX_SEND) accepted_ops++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(0, 12);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_results != 0);
  endtask

  task automatic run_episode();
    int               kind;
    int               len;
    int               roll;
    logic [PORT_W-1:0] port;
    kind = $urandom_range(99);
    port = PORT_W'($urandom_range(3));
    if (kind < 30) begin
      len = $urandom_range(4, 40);
      repeat (len) begin
        roll = $urandom_range(99);
        if (roll < 55)      push_item(OP_RX_STORE, port, BYTE_W'($urandom_range(255)));
        else if (roll < 85) push_item(OP_RX_READ, port, BYTE_W'($urandom_range(255)));
        else                push_item(OP_RX_PEEK, port, BYTE_W'($urandom_range(255)));
      end
    end else if (kind < 60) begin
      len = $urandom_range(4, 40);
      repeat (len) begin
        if ($urandom_range(99) < 55)
          push_item(OP_TX_WRITE, port, BYTE_W'($urandom_range(255)));
        else
          push_item(OP_TX_SEND, port, BYTE_W'($urandom_range(255)));
      end
    end else if (kind < 76) begin
      len = $urandom_range(10, 80);
      repeat (len) begin
        roll = $urandom_range(9);
        if (roll < 4)      push_item(OP_RX_READ, port, BYTE_W'($urandom_range(255)));
        else if (roll < 5) push_item(OP_RX_PEEK, port, BYTE_W'($urandom_range(255)));
        else               push_item(OP_TX_SEND, port, BYTE_W'($urandom_range(255)));
      end
    end else if (kind < 94) begin
      len = $urandom_range(5, 30);
      repeat (len) begin
        push_item(OP_W'($urandom_range(7)), PORT_W'($urandom_range(3)),
                  BYTE_W'($urandom_range(255)));
      end
    end else if (kind < 97) begin
      len = $urandom_range(60, 72);
      repeat (len) push_item(OP_RX_STORE, port, BYTE_W'($urandom_range(255)));
    end else begin
      len = $urandom_range(124, 136);
      repeat (len) push_item(OP_TX_WRITE, port, BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty rings straight after reset, then the unknown operations.
    push_item(OP_RX_READ, 2'd0, 8'hFF);
    push_item(OP_RX_PEEK, 2'd1, 8'hFF);
    push_item(OP_TX_SEND, 2'd2, 8'hFF);
    push_item(3'd5, 2'd3, 8'h00);
    push_item(3'd6, 2'd3, 8'hFF);
    push_item(3'd7, 2'd3, 8'hAA);

    push_item(OP_RX_STORE, 2'd0, 8'hFF);
    push_item(OP_RX_STORE, 2'd0, 8'h00);
    push_item(OP_RX_PEEK, 2'd0, 8'h00);
    push_item(OP_RX_READ, 2'd0, 8'h00);
    push_item(OP_RX_READ, 2'd0, 8'h00);
    push_item(OP_RX_READ, 2'd0, 8'h00);
    push_item(OP_RX_PEEK, 2'd0, 8'h00);

    push_item(OP_TX_WRITE, 2'd3, 8'hFF);
    push_item(OP_TX_WRITE, 2'd3, 8'h00);
    push_item(OP_TX_WRITE, 2'd3, 8'h5A);
    push_item(OP_TX_SEND, 2'd3, 8'h00);
    push_item(OP_TX_SEND, 2'd3, 8'h00);
    push_item(OP_TX_SEND, 2'd3, 8'h00);
    push_item(OP_TX_SEND, 2'd3, 8'h00);
    push_item(OP_RX_STORE, 2'd2, 8'hA5);
    push_item(OP_TX_WRITE, 2'd1, 8'h3C);
    wait_for_results();

    while (accepted_ops < ITEM_TARGET) begin
      run_episode();
      if ($urandom_range(24) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
